/* design/smc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil moisture conditioner package
// Shared types, operation codes and arithmetic constants.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam logic [6:0]  RAW_MAX       = 7'd100;
    localparam logic [6:0]  EXTREME_LOW   = 7'd5;
    localparam logic [6:0]  EXTREME_HIGH  = 7'd95;
    localparam logic [6:0]  CLAMP_LOW     = 7'd5;
    localparam logic [6:0]  CLAMP_HIGH    = 7'd95;
    localparam logic [6:0]  LAST_RESET    = 7'd50;
    localparam logic [3:0]  STREAK_MAX    = 4'd15;
    localparam logic [3:0]  WARN_LIMIT    = 4'd3;
    localparam logic [3:0]  HOLD_LIMIT    = 4'd5;
    localparam logic [9:0]  BLEND_WEIGHT  = 10'd9;

    // Reciprocals for exact truncating division by constants.
    localparam logic [11:0] RECIP_3       = 12'd2731;
    localparam int          SHIFT_3       = 13;
    localparam logic [17:0] RECIP_1023    = 18'd131201;
    localparam int          SHIFT_1023    = 27;
    localparam logic [7:0]  RECIP_10      = 8'd205;
    localparam int          SHIFT_10      = 11;
    localparam int          SHIFT_FILL    = 16;

    typedef enum logic [1:0] {
        STAT_FRESH    = 2'd0,
        STAT_MISMATCH = 2'd1,
        STAT_EXTREME  = 2'd2
    } t_smc_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_AVG,
        OP_SCALE,
        OP_RAW,
        OP_CHECK,
        OP_SUM,
        OP_MEAN,
        OP_BLEND,
        OP_CLAMP
    } t_smc_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_SCALE,
        ST_RAW,
        ST_CHECK,
        ST_SUM,
        ST_MEAN,
        ST_BLEND,
        ST_CLAMP,
        ST_DONE
    } t_smc_state;

    typedef struct packed {
        t_smc_op op;
        logic    out_load;
    } t_smc_cmd;

    typedef struct packed {
        logic hold;
        logic sum_last;
    } t_smc_stat;

    // Ceiling of 2^16 / fill for fill counts of one to sixteen.
    function automatic logic [16:0] fill_recip(input logic [4:0] fill);
        logic [16:0] r;
        unique case (fill)
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd32768;
            5'd3:    r = 17'd21846;
            5'd4:    r = 17'd16384;
            5'd5:    r = 17'd13108;
            5'd6:    r = 17'd10923;
            5'd7:    r = 17'd9363;
            5'd8:    r = 17'd8192;
            5'd9:    r = 17'd7282;
            5'd10:   r = 17'd6554;
            5'd11:   r = 17'd5958;
            5'd12:   r = 17'd5462;
            5'd13:   r = 17'd5042;
            5'd14:   r = 17'd4682;
            5'd15:   r = 17'd4370;
            5'd16:   r = 17'd4096;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

/* design/smc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil moisture reading channel
// Valid/ready channel carrying the probe bits and the three ADC samples.
// ----------------------------------------------------------------------------
interface smc_in_if;
    logic       valid;
    logic       ready;
    logic       probe_bit_first;
    logic       probe_bit_second;
    logic [9:0] adc_sample_a;
    logic [9:0] adc_sample_b;
    logic [9:0] adc_sample_c;

    modport source (
        output valid, probe_bit_first, probe_bit_second,
        output adc_sample_a, adc_sample_b, adc_sample_c,
        input  ready
    );
    modport sink (
        input  valid, probe_bit_first, probe_bit_second,
        input  adc_sample_a, adc_sample_b, adc_sample_c,
        output ready
    );
endinterface

/* design/smc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil moisture result channel
// Valid/ready channel carrying the conditioned percentage and status.
// ----------------------------------------------------------------------------
interface smc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] moisture_percent;
    logic [1:0] status;
    logic       disconnect_warning;

    modport source (
        output valid, moisture_percent, status, disconnect_warning,
        input  ready
    );
    modport sink (
        input  valid, moisture_percent, status, disconnect_warning,
        output ready
    );
endinterface

/* design/smc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil moisture conditioner controller
// Sequences the datapath through one reading and owns the result valid flag.
// ----------------------------------------------------------------------------
module smc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  smc_pkg::t_smc_stat i_stat,
    output smc_pkg::t_smc_cmd  o_cmd
);

    smc_pkg::t_smc_state r_state;
    smc_pkg::t_smc_state n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smc_pkg::ST_IDLE:  if (i_in_valid) n_state = smc_pkg::ST_AVG;
            smc_pkg::ST_AVG:   n_state = smc_pkg::ST_SCALE;
            smc_pkg::ST_SCALE: n_state = smc_pkg::ST_RAW;
            smc_pkg::ST_RAW:   n_state = smc_pkg::ST_CHECK;
            smc_pkg::ST_CHECK: begin
                n_state = i_stat.hold ? smc_pkg::ST_DONE : smc_pkg::ST_SUM;
            end
            smc_pkg::ST_SUM:   if (i_stat.sum_last) n_state = smc_pkg::ST_MEAN;
            smc_pkg::ST_MEAN:  n_state = smc_pkg::ST_BLEND;
            smc_pkg::ST_BLEND: n_state = smc_pkg::ST_CLAMP;
            smc_pkg::ST_CLAMP: n_state = smc_pkg::ST_DONE;
            smc_pkg::ST_DONE:  if (out_free) n_state = smc_pkg::ST_IDLE;
            default:           n_state = smc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.op     = smc_pkg::OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            smc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = smc_pkg::OP_LOAD;
            end
            smc_pkg::ST_AVG:   o_cmd.op = smc_pkg::OP_AVG;
            smc_pkg::ST_SCALE: o_cmd.op = smc_pkg::OP_SCALE;
            smc_pkg::ST_RAW:   o_cmd.op = smc_pkg::OP_RAW;
            smc_pkg::ST_CHECK: o_cmd.op = smc_pkg::OP_CHECK;
            smc_pkg::ST_SUM:   o_cmd.op = smc_pkg::OP_SUM;
            smc_pkg::ST_MEAN:  o_cmd.op = smc_pkg::OP_MEAN;
            smc_pkg::ST_BLEND: o_cmd.op = smc_pkg::OP_BLEND;
            smc_pkg::ST_CLAMP: o_cmd.op = smc_pkg::OP_CLAMP;
            smc_pkg::ST_DONE:  o_cmd.out_load = out_free;
            default:           o_cmd.op = smc_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* design/smc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil moisture conditioner datapath
// Sample averaging, extreme tracking, window ring, mean, blend and clamp.
// ----------------------------------------------------------------------------
module smc_datapath #(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_probe_bit_first,
    input  logic               i_probe_bit_second,
    input  logic [9:0]         i_adc_sample_a,
    input  logic [9:0]         i_adc_sample_b,
    input  logic [9:0]         i_adc_sample_c,
    input  smc_pkg::t_smc_cmd  i_cmd,
    output smc_pkg::t_smc_stat o_stat,
    output logic [6:0]         o_moisture_percent,
    output logic [1:0]         o_status,
    output logic               o_disconnect_warning
);

    localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = $clog2(100 * WINDOW_DEPTH + 1);

    logic                r_digital_mode;
    logic [6:0]          r_last;
    logic [POS_W-1:0]    r_pos;
    logic [FILL_W-1:0]   r_fill;
    logic [3:0]          r_streak;
    logic [6:0]          r_window [WINDOW_DEPTH];

    logic                r_bit_first;
    logic                r_bit_second;
    logic [11:0]         r_sum3;
    logic [9:0]          r_avg;
    logic [16:0]         r_prod;
    logic [6:0]          r_raw;
    logic [SUM_W-1:0]    r_acc;
    logic [POS_W-1:0]    r_idx;
    logic [6:0]          r_mean;
    logic [9:0]          r_mix;
    logic [6:0]          r_val;
    smc_pkg::t_smc_status r_stat;
    logic                r_warn;

    logic [6:0]          r_out_percent;
    logic [1:0]          r_out_status;
    logic                r_out_warn;

    logic [23:0]         avg_mul;
    logic [34:0]         raw_mul;
    logic [6:0]          analog_raw;
    logic                extreme;
    logic [3:0]          streak_inc;
    logic                hold;
    logic [SUM_W+16:0]   mean_mul;
    logic [17:0]         blend_mul;
    logic [6:0]          blend_q;
    logic [6:0]          blend_clamped;
    logic [FILL_W-1:0]   fill_inc;

    assign avg_mul   = {12'd0, r_sum3} * {12'd0, smc_pkg::RECIP_3};
    assign raw_mul   = {18'd0, r_prod} * {17'd0, smc_pkg::RECIP_1023};
    assign analog_raw = smc_pkg::RAW_MAX - raw_mul[smc_pkg::SHIFT_1023 +: 7];

    assign extreme    = (r_raw <= smc_pkg::EXTREME_LOW) || (r_raw >= smc_pkg::EXTREME_HIGH);
    assign streak_inc = (r_streak < smc_pkg::STREAK_MAX) ? r_streak + 4'd1 : r_streak;
    assign hold       = r_digital_mode ? (r_bit_first != r_bit_second)
                                       : (extreme && (streak_inc > smc_pkg::HOLD_LIMIT));
    assign fill_inc   = (r_fill < FILL_W'(WINDOW_DEPTH)) ? r_fill + FILL_W'(1) : r_fill;

    assign mean_mul  = {17'd0, r_acc} *
                       {{SUM_W{1'b0}}, smc_pkg::fill_recip(5'(r_fill))};
    assign blend_mul = {8'd0, r_mix} * {10'd0, smc_pkg::RECIP_10};
    assign blend_q   = blend_mul[smc_pkg::SHIFT_10 +: 7];

    always_comb begin
        blend_clamped = blend_q;
        if (blend_q < smc_pkg::CLAMP_LOW) begin
            blend_clamped = smc_pkg::CLAMP_LOW;
        end else if (blend_q > smc_pkg::CLAMP_HIGH) begin
            blend_clamped = smc_pkg::CLAMP_HIGH;
        end
    end

    assign o_stat.hold     = hold;
    assign o_stat.sum_last = (FILL_W'(r_idx) == (r_fill - FILL_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digital_mode <= 1'b0;
            r_last         <= smc_pkg::LAST_RESET;
            r_pos          <= '0;
            r_fill         <= '0;
            r_streak       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_digital_mode <= i_cfg_data;
            end
            if (i_cmd.op == smc_pkg::OP_CHECK) begin
                if (!r_digital_mode) begin
                    r_streak <= extreme ? streak_inc : 4'd0;
                end
                if (!hold) begin
                    r_pos  <= (r_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_pos + POS_W'(1);
                    r_fill <= fill_inc;
                end
            end
            if (i_cmd.op == smc_pkg::OP_CLAMP) begin
                r_last <= blend_clamped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            smc_pkg::OP_LOAD: begin
                r_bit_first  <= i_probe_bit_first;
                r_bit_second <= i_probe_bit_second;
                r_sum3       <= {2'd0, i_adc_sample_a} + {2'd0, i_adc_sample_b}
                                + {2'd0, i_adc_sample_c};
            end
            smc_pkg::OP_AVG: begin
                r_avg <= avg_mul[smc_pkg::SHIFT_3 +: 10];
            end
            smc_pkg::OP_SCALE: begin
                r_prod <= {7'd0, r_avg} * {10'd0, smc_pkg::RAW_MAX};
            end
            smc_pkg::OP_RAW: begin
                if (r_digital_mode) begin
                    r_raw <= r_bit_first ? 7'd0 : smc_pkg::RAW_MAX;
                end else begin
                    r_raw <= analog_raw;
                end
            end
            smc_pkg::OP_CHECK: begin
                r_acc  <= '0;
                r_idx  <= '0;
                r_val  <= r_last;
                r_warn <= !r_digital_mode && extreme && (streak_inc > smc_pkg::WARN_LIMIT);
                if (r_digital_mode) begin
                    r_stat <= hold ? smc_pkg::STAT_MISMATCH : smc_pkg::STAT_FRESH;
                end else begin
                    r_stat <= hold ? smc_pkg::STAT_EXTREME : smc_pkg::STAT_FRESH;
                end
                if (!hold) begin
                    r_window[r_pos] <= r_raw;
                end
            end
            smc_pkg::OP_SUM: begin
                r_acc <= r_acc + SUM_W'(r_window[r_idx]);
                r_idx <= r_idx + POS_W'(1);
            end
            smc_pkg::OP_MEAN: begin
                r_mean <= mean_mul[smc_pkg::SHIFT_FILL +: 7];
            end
            smc_pkg::OP_BLEND: begin
                r_mix <= {3'd0, r_last} * smc_pkg::BLEND_WEIGHT + {3'd0, r_mean};
            end
            smc_pkg::OP_CLAMP: begin
                r_val <= blend_clamped;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out_percent <= r_val;
            r_out_status  <= r_stat;
            r_out_warn    <= r_warn;
        end
    end

    assign o_moisture_percent   = r_out_percent;
    assign o_status             = r_out_status;
    assign o_disconnect_warning = r_out_warn;

endmodule

/* design/soil_moisture_conditioner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil moisture conditioner
// Converts probe readings into a window-averaged, IIR-smoothed percentage.
//
//   Channel   Direction  Transaction
//   i_in      sink       one reading: two probe bits, three ADC samples
//   o_out     source     percentage, status code and disconnect warning
//   i_cfg_*   write      digital_mode register, no read-back
//
// A fresh value runs AVG, SCALE, RAW, CHECK, SUM, MEAN, BLEND, CLAMP and DONE;
// SUM adds the N filled window entries (up to WINDOW_DEPTH) one per cycle. A
// held value goes from CHECK to DONE. One reading is processed at a time; the
// output register lets the next reading start while a result waits.
// Reset is synchronous, active low; the window contents need no clearing.
// ----------------------------------------------------------------------------
module soil_moisture_conditioner #(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    smc_in_if.sink     i_in,
    smc_out_if.source  o_out
);

    smc_pkg::t_smc_cmd  cmd;
    smc_pkg::t_smc_stat stat;

    smc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    smc_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_data           (i_cfg_data),
        .i_probe_bit_first    (i_in.probe_bit_first),
        .i_probe_bit_second   (i_in.probe_bit_second),
        .i_adc_sample_a       (i_in.adc_sample_a),
        .i_adc_sample_b       (i_in.adc_sample_b),
        .i_adc_sample_c       (i_in.adc_sample_c),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .o_moisture_percent   (o_out.moisture_percent),
        .o_status             (o_out.status),
        .o_disconnect_warning (o_out.disconnect_warning)
    );

endmodule
